// File: rtl/text_to_unsigned_integer_parser_defines.svh
// ============================================================================
// Parser assertion macros
// Shared property forms for the checks at the end of the parser top level.
// ============================================================================
`ifndef TEXT_TO_UNSIGNED_INTEGER_PARSER_DEFINES_SVH
`define TEXT_TO_UNSIGNED_INTEGER_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define TTUI_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define TTUI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/ttui_pkg.sv
// ============================================================================
// Parser package
// Types and constants shared by the parser blocks, and the character classifier used by the front end.
// ============================================================================
package ttui_pkg;

    localparam int unsigned CH_W     = 8;
    localparam int unsigned BASE_W   = 6;
    localparam int unsigned DIGIT_W  = 6;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned OFFSET_W = 16;

    localparam logic [DIGIT_W-1:0] NO_DIGIT = 6'd63;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_ONE  = 6'd1;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;
    localparam logic [BASE_W-1:0] BASE_MAX  = 6'd36;

    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_LA    = 8'h61;
    localparam logic [CH_W-1:0] CH_LZ    = 8'h7A;
    localparam logic [CH_W-1:0] CH_UA    = 8'h41;
    localparam logic [CH_W-1:0] CH_UZ    = 8'h5A;
    localparam logic [CH_W-1:0] CH_LX    = 8'h78;
    localparam logic [CH_W-1:0] CH_UX    = 8'h58;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_XSEEN,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic                start;
        logic [BASE_W-1:0]   base;
        logic [DIGIT_W-1:0]  digit;
        logic                is_space;
        logic                is_plus;
        logic                is_minus;
        logic                is_zero;
        logic                is_x;
    } item_t;

    typedef struct packed {
        logic pop;
        logic emit;
    } back_stat_t;

    function automatic logic [DIGIT_W-1:0] digit_value(input logic [CH_W-1:0] c);
        logic [DIGIT_W-1:0] d;
        d = NO_DIGIT;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d = DIGIT_W'(c - CH_ZERO);
        end
        else if (c >= CH_LA && c <= CH_LZ) begin
            d = DIGIT_W'(c - CH_LA + 8'd10);
        end
        else if (c >= CH_UA && c <= CH_UZ) begin
            d = DIGIT_W'(c - CH_UA + 8'd10);
        end
        return d;
    endfunction

endpackage

// File: rtl/ttui_if.sv
// ============================================================================
// Parser channel interfaces
// Valid/ready channels for incoming characters and outgoing parse results.
// ============================================================================
interface ttui_char_if;
    logic                       valid;
    logic                       ready;
    logic [ttui_pkg::CH_W-1:0]  ch;
    logic                       start_req;

    modport source (output valid, output ch, output start_req, input ready);
    modport sink   (input valid, input ch, input start_req, output ready);
endinterface

interface ttui_result_if;
    logic                           valid;
    logic                           ready;
    logic [ttui_pkg::VALUE_W-1:0]   value;
    logic                           overflow;
    logic                           digits_found;
    logic [ttui_pkg::OFFSET_W-1:0]  end_offset;

    modport source (output valid, output value, output overflow, output digits_found,
                    output end_offset, input ready);
    modport sink   (input valid, input value, input overflow, input digits_found,
                    input end_offset, output ready);
endinterface

// File: rtl/text_to_unsigned_integer_parser.sv
// ============================================================================
// Text to unsigned integer parser
// Streams characters through a classifying front end, a two-entry queue and
// a parsing back end that reports one result per string.
// ============================================================================
// Throughput: one character per cycle while the result output is not stalled, set by the
// back end's single multiply-add with overflow check on the accumulator.
// A string's closing character passes through the queue; its result is then held in the back end's output register.
// Reset clears the parser phase, queue pointers and count, and output valid flag; the base register goes to 0.
`include "text_to_unsigned_integer_parser_defines.svh"

module text_to_unsigned_integer_parser #(
    parameter int unsigned WIDTH    = 32,
    parameter int unsigned POS_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ttui_pkg::BASE_W-1:0]   cfg_wdata,
    ttui_char_if.sink                     chars,
    ttui_result_if.source                 results
);

    localparam logic [WIDTH-1:0] MX = '1;

    logic                 q_push;
    logic                 q_ready;
    ttui_pkg::item_t      q_item;
    logic                 head_valid;
    ttui_pkg::item_t      head_item;
    ttui_pkg::back_stat_t back_stat;

    ttui_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (chars.valid),
        .in_ready  (chars.ready),
        .in_ch     (chars.ch),
        .in_start  (chars.start_req),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_item    (q_item)
    );

    ttui_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_item  (q_item),
        .push_ready (q_ready),
        .pop        (back_stat.pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    ttui_back #(
        .WIDTH    (WIDTH),
        .POS_BITS (POS_BITS)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .head_valid       (head_valid),
        .head_item        (head_item),
        .stat             (back_stat),
        .res_valid        (results.valid),
        .res_ready        (results.ready),
        .res_value        (results.value),
        .res_overflow     (results.overflow),
        .res_digits_found (results.digits_found),
        .res_end_offset   (results.end_offset)
    );

    `TTUI_ASSERT_IMPL(a_ovf_saturates, results.valid && results.overflow,
        results.digits_found && (results.value == ttui_pkg::VALUE_W'(MX)),
        "overflow result is not saturated")
    `TTUI_ASSERT_IMPL(a_no_digits_zero, results.valid && !results.digits_found,
        (results.value == '0) && (results.end_offset == '0) && !results.overflow,
        "result without digits is not zero")
    `TTUI_ASSERT_IMPL(a_stall_holds_back, results.valid && !results.ready,
        !back_stat.pop, "back end advanced while result stalled")
    `TTUI_ASSERT_NEXT(a_emit_shows, back_stat.emit, results.valid,
        "emitted result not presented")

endmodule

// File: rtl/ttui_front.sv
// ============================================================================
// Parser front end
// Holds the base register and classifies each accepted character request.
// ============================================================================
module ttui_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ttui_pkg::BASE_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ttui_pkg::CH_W-1:0]     in_ch,
    input  logic                          in_start,
    input  logic                          q_ready,
    output logic                          q_push,
    output ttui_pkg::item_t               q_item
);

    logic [ttui_pkg::BASE_W-1:0] base_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= ttui_pkg::BASE_AUTO;
        end
        else if (cfg_we)
        begin
            base_reg <= cfg_wdata;
        end
    end

    assign in_ready = q_ready;
    assign q_push   = in_valid && q_ready;

    always_comb
    begin
        q_item.start    = in_start;
        q_item.base     = base_reg;
        q_item.digit    = ttui_pkg::digit_value(in_ch);
        q_item.is_space = (in_ch == ttui_pkg::CH_SPACE) ||
                          (in_ch >= ttui_pkg::CH_TAB && in_ch <= ttui_pkg::CH_CR);
        q_item.is_plus  = (in_ch == ttui_pkg::CH_PLUS);
        q_item.is_minus = (in_ch == ttui_pkg::CH_MINUS);
        q_item.is_zero  = (in_ch == ttui_pkg::CH_ZERO);
        q_item.is_x     = (in_ch == ttui_pkg::CH_LX) || (in_ch == ttui_pkg::CH_UX);
    end

endmodule

// File: rtl/ttui_queue.sv
// ============================================================================
// Parser item queue
// Two-entry queue of classified characters between front and back end.
// ============================================================================
module ttui_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ttui_pkg::item_t push_item,
    output logic            push_ready,
    input  logic            pop,
    output logic            head_valid,
    output ttui_pkg::item_t head_item
);

    ttui_pkg::item_t entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_item  = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: rtl/ttui_back.sv
// ============================================================================
// Parser back end
// Runs the parse state machine with one multiply-add per character and
// holds the result in an output register.
// ============================================================================
module ttui_back #(
    parameter int unsigned WIDTH    = 32,
    parameter int unsigned POS_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               head_valid,
    input  ttui_pkg::item_t                    head_item,
    output ttui_pkg::back_stat_t               stat,
    output logic                               res_valid,
    input  logic                               res_ready,
    output logic [ttui_pkg::VALUE_W-1:0]       res_value,
    output logic                               res_overflow,
    output logic                               res_digits_found,
    output logic [ttui_pkg::OFFSET_W-1:0]      res_end_offset
);

    localparam int unsigned PW = WIDTH + ttui_pkg::BASE_W;
    localparam logic [WIDTH-1:0] MX = '1;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    ttui_pkg::phase_t            phase_reg;
    ttui_pkg::phase_t            phase_next;
    logic                        neg_reg;
    logic                        neg_next;
    logic [WIDTH-1:0]            acc_reg;
    logic [WIDTH-1:0]            acc_next;
    logic                        any_reg;
    logic                        any_next;
    logic [ttui_pkg::BASE_W-1:0] base_reg;
    logic [ttui_pkg::BASE_W-1:0] base_next;
    logic [POS_BITS-1:0]         pos_reg;
    logic [POS_BITS-1:0]         pos_next;
    logic [POS_BITS-1:0]         xm_reg;
    logic [POS_BITS-1:0]         xm_next;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [ttui_pkg::VALUE_W-1:0]   out_value_reg;
    logic [ttui_pkg::VALUE_W-1:0]   out_value_next;
    logic                           out_ovf_reg;
    logic                           out_ovf_next;
    logic                           out_dig_reg;
    logic                           out_dig_next;
    logic [ttui_pkg::OFFSET_W-1:0]  out_end_reg;
    logic [ttui_pkg::OFFSET_W-1:0]  out_end_next;

    ttui_pkg::phase_t            cur_phase;
    logic                        cur_neg;
    logic [WIDTH-1:0]            cur_acc;
    logic                        cur_any;
    logic [ttui_pkg::BASE_W-1:0] cur_base;
    logic [POS_BITS-1:0]         cur_pos;
    logic [POS_BITS-1:0]         cur_xm;
    logic                        advance;
    logic                        emit;
    logic                        do_digit;
    logic                        do_finish;
    logic                        counts;
    logic [ttui_pkg::BASE_W-1:0] dbase;
    logic [POS_BITS-1:0]         fin_pos;
    logic [PW-1:0]               prod;
    logic [WIDTH-1:0]            emit_value;
    logic                        emit_ovf;
    logic                        emit_dig;
    logic [POS_BITS-1:0]         emit_pos;

    assign advance = head_valid && (!out_valid_reg || res_ready);

    always_comb
    begin
        if (head_item.start)
        begin
            cur_phase = ttui_pkg::PH_LEAD;
            cur_neg   = 1'b0;
            cur_acc   = '0;
            cur_any   = 1'b0;
            cur_base  = head_item.base;
            cur_pos   = '0;
            cur_xm    = '0;
        end
        else
        begin
            cur_phase = phase_reg;
            cur_neg   = neg_reg;
            cur_acc   = acc_reg;
            cur_any   = any_reg;
            cur_base  = base_reg;
            cur_pos   = pos_reg;
            cur_xm    = xm_reg;
        end

        phase_next = cur_phase;
        neg_next   = cur_neg;
        acc_next   = cur_acc;
        any_next   = cur_any;
        base_next  = cur_base;
        xm_next    = cur_xm;
        do_digit   = 1'b0;
        do_finish  = 1'b0;
        fin_pos    = cur_pos;
        dbase      = cur_base;
        counts     = 1'b1;
        emit       = 1'b0;
        emit_value = '0;
        emit_ovf   = 1'b0;
        emit_dig   = 1'b0;
        emit_pos   = '0;

        case (cur_phase)
            ttui_pkg::PH_LEAD, ttui_pkg::PH_SIGNED:
            begin
                if (cur_phase == ttui_pkg::PH_LEAD && head_item.is_space)
                begin
                    phase_next = cur_phase;
                end
                else if (cur_phase == ttui_pkg::PH_LEAD &&
                         (head_item.is_plus || head_item.is_minus))
                begin
                    neg_next   = head_item.is_minus;
                    phase_next = ttui_pkg::PH_SIGNED;
                end
                else if ((cur_base == ttui_pkg::BASE_AUTO || cur_base == ttui_pkg::BASE_HEX) &&
                         head_item.is_zero)
                begin
                    acc_next   = '0;
                    any_next   = 1'b1;
                    phase_next = ttui_pkg::PH_ZERO;
                end
                else
                begin
                    dbase      = (cur_base == ttui_pkg::BASE_AUTO) ? ttui_pkg::BASE_DEC
                                                                   : cur_base;
                    phase_next = ttui_pkg::PH_DIGITS;
                    do_digit   = 1'b1;
                end
            end
            ttui_pkg::PH_ZERO:
            begin
                if (head_item.is_x)
                begin
                    xm_next    = cur_pos;
                    phase_next = ttui_pkg::PH_XSEEN;
                end
                else
                begin
                    dbase      = (cur_base == ttui_pkg::BASE_AUTO) ? ttui_pkg::BASE_OCT
                                                                   : cur_base;
                    phase_next = ttui_pkg::PH_DIGITS;
                    do_digit   = 1'b1;
                end
            end
            ttui_pkg::PH_XSEEN:
            begin
                if (head_item.digit < ttui_pkg::DIGIT_W'(ttui_pkg::BASE_HEX))
                begin
                    dbase      = ttui_pkg::BASE_HEX;
                    phase_next = ttui_pkg::PH_DIGITS;
                    do_digit   = 1'b1;
                end
                else
                begin
                    do_finish = 1'b1;
                    fin_pos   = cur_xm;
                end
            end
            ttui_pkg::PH_DIGITS:
            begin
                do_digit = 1'b1;
            end
            default:
            begin
                counts = 1'b0;
            end
        endcase

        base_next = do_digit ? dbase : base_next;
        prod = PW'(cur_acc) * PW'(dbase) + PW'(head_item.digit);

        if (do_digit)
        begin
            if (head_item.digit >= ttui_pkg::DIGIT_W'(dbase))
            begin
                do_finish = 1'b1;
            end
            else if (|prod[PW-1:WIDTH])
            begin
                acc_next   = MX;
                any_next   = 1'b1;
                emit       = 1'b1;
                emit_value = MX;
                emit_ovf   = 1'b1;
                emit_dig   = 1'b1;
                emit_pos   = cur_pos;
            end
            else
            begin
                acc_next = prod[WIDTH-1:0];
                any_next = 1'b1;
            end
        end

        if (do_finish)
        begin
            emit       = 1'b1;
            emit_value = (cur_neg && cur_any) ? (WIDTH'(0) - cur_acc) : cur_acc;
            emit_ovf   = 1'b0;
            emit_dig   = cur_any;
            emit_pos   = cur_any ? fin_pos : '0;
        end

        pos_next = (counts && cur_pos != POS_MAX) ? cur_pos + POS_BITS'(1) : cur_pos;

        if (head_item.start &&
            (head_item.base == ttui_pkg::BASE_ONE || head_item.base > ttui_pkg::BASE_MAX))
        begin
            phase_next = ttui_pkg::PH_DONE;
            base_next  = head_item.base;
            pos_next   = POS_BITS'(1);
            emit       = 1'b1;
            emit_value = '0;
            emit_ovf   = 1'b0;
            emit_dig   = 1'b0;
            emit_pos   = '0;
        end
        else if (emit)
        begin
            phase_next = ttui_pkg::PH_DONE;
        end

        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_ovf_next   = out_ovf_reg;
        out_dig_next   = out_dig_reg;
        out_end_next   = out_end_reg;
        if (advance && emit)
        begin
            out_valid_next = 1'b1;
            out_value_next = ttui_pkg::VALUE_W'(emit_value);
            out_ovf_next   = emit_ovf;
            out_dig_next   = emit_dig;
            out_end_next   = ttui_pkg::OFFSET_W'(emit_pos);
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ttui_pkg::PH_IDLE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            any_reg       <= 1'b0;
            base_reg      <= '0;
            pos_reg       <= '0;
            xm_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                any_reg   <= any_next;
                base_reg  <= base_next;
                pos_reg   <= pos_next;
                xm_reg    <= xm_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_value_reg <= out_value_next;
        out_ovf_reg   <= out_ovf_next;
        out_dig_reg   <= out_dig_next;
        out_end_reg   <= out_end_next;
    end

    assign stat.pop         = advance;
    assign stat.emit        = advance && emit;
    assign res_valid        = out_valid_reg;
    assign res_value        = out_value_reg;
    assign res_overflow     = out_ovf_reg;
    assign res_digits_found = out_dig_reg;
    assign res_end_offset   = out_end_reg;

endmodule

// File: dv/text_to_unsigned_integer_parser_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Text to unsigned integer parser testbench
// Streams characters into the parser through valid/ready channels and checks
// every parse result against a cycle-free model of the parsing rules. A short
// table of directed strings is followed by randomly composed strings over many
// base settings, with random idle cycles on both channels.
// ============================================================================
module text_to_unsigned_integer_parser_tb;

    localparam int unsigned DIRECTED_ROWS = 26;
    localparam int unsigned RANDOM_ITEMS  = 1700;
    localparam int unsigned DRAIN_CYCLES  = 8;
    localparam int unsigned LONG_HOLD     = 80;
    localparam int unsigned STALL_LIMIT   = 1000;
    localparam int unsigned REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [ttui_pkg::VALUE_W-1:0]  value;
        logic                          overflow;
        logic                          digits_found;
        logic [ttui_pkg::OFFSET_W-1:0] end_offset;
    } parse_result_t;

    typedef struct packed {
        logic                        set_base;
        logic [ttui_pkg::BASE_W-1:0] base;
        logic [ttui_pkg::CH_W-1:0]   ch;
        logic                        start;
        logic                        typed;
        parse_result_t               result;
    } string_step_t;

    localparam parse_result_t NO_RESULT = '0;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [ttui_pkg::BASE_W-1:0] cfg_wdata;

    ttui_char_if   char_bus ();
    ttui_result_if result_bus ();

    text_to_unsigned_integer_parser uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .chars     (char_bus),
        .results   (result_bus)
    );

    always #10 clk = ~clk;

    // Parser state as the checker sees it.
    ttui_pkg::phase_t              parse_phase = ttui_pkg::PH_IDLE;
    bit                            neg_sign    = 1'b0;
    logic [ttui_pkg::VALUE_W-1:0]  accum       = '0;
    bit                            seen_digit  = 1'b0;
    logic [ttui_pkg::BASE_W-1:0]   cur_base    = ttui_pkg::BASE_AUTO;
    logic [ttui_pkg::OFFSET_W-1:0] char_pos    = '0;
    logic [ttui_pkg::OFFSET_W-1:0] x_pos       = '0;
    logic [ttui_pkg::BASE_W-1:0]   base_reg    = ttui_pkg::BASE_AUTO;

    parse_result_t expected_results[$];
    string_step_t  directed_steps [0:DIRECTED_ROWS-1];

    int unsigned fail_count  = 0;
    int unsigned result_seen = 0;
    int unsigned live_chars  = 0;
    int unsigned idle_cycles = 0;
    bit          tx_burst    = 1'b0;
    bit          rx_burst    = 1'b0;
    bit          rx_hold_req = 1'b0;

    function automatic logic [ttui_pkg::DIGIT_W-1:0] digit_of(
        input logic [ttui_pkg::CH_W-1:0] c);
        if (c inside {[ttui_pkg::CH_ZERO:ttui_pkg::CH_NINE]})
        begin
            return ttui_pkg::DIGIT_W'(c - ttui_pkg::CH_ZERO);
        end
        if (c inside {[ttui_pkg::CH_LA:ttui_pkg::CH_LZ]})
        begin
            return ttui_pkg::DIGIT_W'(c - ttui_pkg::CH_LA + 10);
        end
        if (c inside {[ttui_pkg::CH_UA:ttui_pkg::CH_UZ]})
        begin
            return ttui_pkg::DIGIT_W'(c - ttui_pkg::CH_UA + 10);
        end
        return ttui_pkg::NO_DIGIT;
    endfunction

    function automatic bit close_out(input logic [ttui_pkg::VALUE_W-1:0] v, input bit ovf,
                                     input bit dig,
                                     input logic [ttui_pkg::OFFSET_W-1:0] endp,
                                     output parse_result_t r);
        r.value        = v;
        r.overflow     = ovf;
        r.digits_found = dig;
        r.end_offset   = dig ? endp : '0;
        parse_phase    = ttui_pkg::PH_DONE;
        return 1'b1;
    endfunction

    function automatic bit finish_number(input logic [ttui_pkg::OFFSET_W-1:0] endp,
                                         output parse_result_t r);
        logic [ttui_pkg::VALUE_W-1:0] v;
        v = accum;
        if (neg_sign && seen_digit)
        begin
            v = -accum;
        end
        return close_out(v, 1'b0, seen_digit, endp, r);
    endfunction

    function automatic bit accept_digit(input logic [ttui_pkg::CH_W-1:0] c,
                                        input logic [ttui_pkg::OFFSET_W-1:0] pos,
                                        output parse_result_t r);
        logic [ttui_pkg::DIGIT_W-1:0] d;
        logic [63:0]                  wide;
        d = digit_of(c);
        if (d >= cur_base)
        begin
            return finish_number(pos, r);
        end
        wide = 64'(accum) * 64'(cur_base) + 64'(d);
        seen_digit = 1'b1;
        if (wide > 64'({ttui_pkg::VALUE_W{1'b1}}))
        begin
            accum = '1;
            return close_out('1, 1'b1, 1'b1, pos, r);
        end
        accum = wide[ttui_pkg::VALUE_W-1:0];
        return 1'b0;
    endfunction

    function automatic bit first_significant(input logic [ttui_pkg::CH_W-1:0] c,
                                             input logic [ttui_pkg::OFFSET_W-1:0] pos,
                                             output parse_result_t r);
        if ((cur_base == ttui_pkg::BASE_AUTO || cur_base == ttui_pkg::BASE_HEX) &&
            c == ttui_pkg::CH_ZERO)
        begin
            accum       = '0;
            seen_digit  = 1'b1;
            parse_phase = ttui_pkg::PH_ZERO;
            return 1'b0;
        end
        if (cur_base == ttui_pkg::BASE_AUTO)
        begin
            cur_base = ttui_pkg::BASE_DEC;
        end
        parse_phase = ttui_pkg::PH_DIGITS;
        return accept_digit(c, pos, r);
    endfunction

    // Advances the parser state by one character; returns 1 when a result is due.
    function automatic bit predict_char(input logic [ttui_pkg::CH_W-1:0] c, input logic st,
                                        output parse_result_t r);
        logic [ttui_pkg::OFFSET_W-1:0] pos;
        bit                            got;
        got = 1'b0;
        r   = NO_RESULT;
        if (st)
        begin
            neg_sign    = 1'b0;
            accum       = '0;
            seen_digit  = 1'b0;
            x_pos       = '0;
            char_pos    = '0;
            cur_base    = base_reg;
            parse_phase = ttui_pkg::PH_LEAD;
            if (cur_base == ttui_pkg::BASE_ONE || cur_base > ttui_pkg::BASE_MAX)
            begin
                char_pos = ttui_pkg::OFFSET_W'(1);
                return close_out('0, 1'b0, 1'b0, '0, r);
            end
        end
        if (parse_phase == ttui_pkg::PH_IDLE || parse_phase == ttui_pkg::PH_DONE)
        begin
            return 1'b0;
        end
        pos = char_pos;
        case (parse_phase)
            ttui_pkg::PH_LEAD:
            begin
                if (c == ttui_pkg::CH_SPACE ||
                    c inside {[ttui_pkg::CH_TAB:ttui_pkg::CH_CR]})
                begin
                    got = 1'b0;
                end
                else if (c == ttui_pkg::CH_MINUS || c == ttui_pkg::CH_PLUS)
                begin
                    neg_sign    = (c == ttui_pkg::CH_MINUS);
                    parse_phase = ttui_pkg::PH_SIGNED;
                end
                else
                begin
                    got = first_significant(c, pos, r);
                end
            end
            ttui_pkg::PH_SIGNED:
            begin
                got = first_significant(c, pos, r);
            end
            ttui_pkg::PH_ZERO:
            begin
                if (c == ttui_pkg::CH_LX || c == ttui_pkg::CH_UX)
                begin
                    x_pos       = pos;
                    parse_phase = ttui_pkg::PH_XSEEN;
                end
                else
                begin
                    if (cur_base == ttui_pkg::BASE_AUTO)
                    begin
                        cur_base = ttui_pkg::BASE_OCT;
                    end
                    parse_phase = ttui_pkg::PH_DIGITS;
                    got = accept_digit(c, pos, r);
                end
            end
            ttui_pkg::PH_XSEEN:
            begin
                if (digit_of(c) < ttui_pkg::BASE_HEX)
                begin
                    cur_base    = ttui_pkg::BASE_HEX;
                    parse_phase = ttui_pkg::PH_DIGITS;
                    got = accept_digit(c, pos, r);
                end
                else
                begin
                    got = finish_number(x_pos, r);
                end
            end
            default:
            begin
                got = accept_digit(c, pos, r);
            end
        endcase
        if (char_pos != '1)
        begin
            char_pos++;
        end
        return got;
    endfunction

    function automatic void log_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("%s", msg);
        end
    endfunction

    function automatic logic [ttui_pkg::BASE_W-1:0] pick_base();
        case ($urandom_range(0, 9))
            0, 1:    return ttui_pkg::BASE_AUTO;
            2:       return ttui_pkg::BASE_HEX;
            3:       return ttui_pkg::BASE_DEC;
            4:       return ttui_pkg::BASE_OCT;
            5:       return ttui_pkg::BASE_W'(2);
            6:       return ttui_pkg::BASE_MAX;
            7, 8:    return ttui_pkg::BASE_W'($urandom_range(2, 36));
            default: return $urandom_range(0, 1) ? ttui_pkg::BASE_ONE
                                                 : ttui_pkg::BASE_W'($urandom_range(37, 63));
        endcase
    endfunction

    // Builds one string; returns 1 for a noise string of random bytes.
    function automatic bit compose_string(input logic [ttui_pkg::BASE_W-1:0] b,
                                          ref logic [ttui_pkg::CH_W-1:0] text[$]);
        int unsigned db;
        int unsigned n;
        int unsigned d;
        text.delete();
        if ($urandom_range(0, 7) == 0)
        begin
            repeat ($urandom_range(1, 8))
                text.push_back(ttui_pkg::CH_W'($urandom_range(0, 255)));
            return 1'b1;
        end
        repeat ($urandom_range(0, 2))
        begin
            n = $urandom_range(0, 5);
            text.push_back((n == 0) ? ttui_pkg::CH_SPACE
                                    : ttui_pkg::CH_W'(ttui_pkg::CH_TAB + n - 1));
        end
        case ($urandom_range(0, 7))
            0, 1: text.push_back(ttui_pkg::CH_PLUS);
            2, 3: text.push_back(ttui_pkg::CH_MINUS);
            4:
            begin
                text.push_back($urandom_range(0, 1) ? ttui_pkg::CH_PLUS : ttui_pkg::CH_MINUS);
                text.push_back($urandom_range(0, 1) ? ttui_pkg::CH_PLUS : ttui_pkg::CH_MINUS);
            end
            default: ;
        endcase
        db = (b >= 2 && b <= ttui_pkg::BASE_MAX) ? int'(b) : 10;
        if ((b == ttui_pkg::BASE_AUTO || b == ttui_pkg::BASE_HEX) && $urandom_range(0, 2) == 0)
        begin
            text.push_back(ttui_pkg::CH_ZERO);
            text.push_back($urandom_range(0, 1) ? ttui_pkg::CH_LX : ttui_pkg::CH_UX);
            db = 16;
        end
        else if (b == ttui_pkg::BASE_AUTO && $urandom_range(0, 2) == 0)
        begin
            text.push_back(ttui_pkg::CH_ZERO);
            db = 8;
        end
        case ($urandom_range(0, 7))
            0:       n = 0;
            6:       n = $urandom_range(9, 16);
            7:       n = $urandom_range(17, 40);
            default: n = $urandom_range(1, 8);
        endcase
        repeat (n)
        begin
            d = $urandom_range(0, db - 1);
            if (d < 10)
            begin
                text.push_back(ttui_pkg::CH_W'(ttui_pkg::CH_ZERO + d));
            end
            else
            begin
                text.push_back(ttui_pkg::CH_W'(($urandom_range(0, 1) ? ttui_pkg::CH_LA
                                                                      : ttui_pkg::CH_UA)
                                               + d - 10));
            end
        end
        text.push_back(($urandom_range(0, 2) == 0) ? 8'h00
                                                   : ttui_pkg::CH_W'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 2))
            text.push_back(ttui_pkg::CH_W'($urandom_range(0, 255)));
        return 1'b0;
    endfunction

    task automatic send_char(input logic [ttui_pkg::CH_W-1:0] c, input logic st,
                             input logic typed, input parse_result_t typed_result);
        int unsigned   gap;
        bit            emitted;
        parse_result_t r;
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        if (gap != 0)
        begin
            char_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        char_bus.valid     <= 1'b1;
        char_bus.ch        <= c;
        char_bus.start_req <= st;
        do
        begin
            @(posedge clk);
        end
        while (!char_bus.ready);
        live_chars++;
        emitted = predict_char(c, st, r);
        if (typed)
        begin
            expected_results.push_back(typed_result);
        end
        else if (emitted)
        begin
            expected_results.push_back(r);
        end
    endtask

    task automatic settle();
        char_bus.valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_base(input logic [ttui_pkg::BASE_W-1:0] b);
        cfg_we    <= 1'b1;
        cfg_wdata <= b;
        @(posedge clk);
        cfg_we   <= 1'b0;
        base_reg  = b;
    endtask

    initial
    begin
        int unsigned                 idx;
        int unsigned                 round;
        logic [ttui_pkg::BASE_W-1:0] base_now;
        logic [ttui_pkg::CH_W-1:0]   text[$];
        bit                          noisy;
        directed_steps = '{
            '{1'b0, ttui_pkg::BASE_AUTO, 8'h35, 1'b0, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, 8'h00, 1'b0, 1'b0, NO_RESULT},
            '{1'b1, 6'd63, 8'h31, 1'b1, 1'b1, NO_RESULT},
            '{1'b1, ttui_pkg::BASE_MAX, ttui_pkg::CH_LZ, 1'b1, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, ttui_pkg::CH_LZ, 1'b0, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, ttui_pkg::CH_LZ, 1'b0, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, ttui_pkg::CH_LZ, 1'b0, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, ttui_pkg::CH_LZ, 1'b0, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, ttui_pkg::CH_LZ, 1'b0, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, ttui_pkg::CH_UZ, 1'b0, 1'b1,
              '{32'hFFFF_FFFF, 1'b1, 1'b1, 16'd6}},
            '{1'b1, ttui_pkg::BASE_AUTO, ttui_pkg::CH_ZERO, 1'b1, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, ttui_pkg::CH_LX, 1'b0, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, 8'hFF, 1'b0, 1'b1, '{32'd0, 1'b0, 1'b1, 16'd1}},
            '{1'b1, ttui_pkg::BASE_AUTO, ttui_pkg::CH_TAB, 1'b1, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, ttui_pkg::CH_MINUS, 1'b0, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, 8'h37, 1'b0, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, 8'h00, 1'b0, 1'b1,
              '{32'hFFFF_FFF9, 1'b0, 1'b1, 16'd3}},
            '{1'b1, 6'd2, ttui_pkg::CH_PLUS, 1'b1, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, ttui_pkg::CH_MINUS, 1'b0, 1'b1, NO_RESULT},
            '{1'b1, ttui_pkg::BASE_HEX, 8'h35, 1'b1, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, ttui_pkg::CH_ZERO, 1'b1, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, ttui_pkg::CH_UX, 1'b0, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, ttui_pkg::CH_LA, 1'b0, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, 8'h00, 1'b0, 1'b0, NO_RESULT},
            '{1'b1, ttui_pkg::BASE_AUTO, ttui_pkg::CH_ZERO, 1'b1, 1'b0, NO_RESULT},
            '{1'b0, ttui_pkg::BASE_AUTO, ttui_pkg::CH_NINE, 1'b0, 1'b0, NO_RESULT}
        };
        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        char_bus.valid     <= 1'b0;
        char_bus.ch        <= '0;
        char_bus.start_req <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (idx = 0; idx < DIRECTED_ROWS; idx++)
        begin
            if (directed_steps[idx].set_base)
            begin
                settle();
                load_base(directed_steps[idx].base);
            end
            send_char(directed_steps[idx].ch, directed_steps[idx].start,
                      directed_steps[idx].typed, directed_steps[idx].result);
        end

        round = 0;
        while (live_chars < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            settle();
            base_now = pick_base();
            load_base(base_now);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst = ($urandom_range(0, 3) == 0);
            // Hold the result side off while requests keep coming, so the block backs up.
            if (round == 2)
            begin
                tx_burst    = 1'b1;
                rx_hold_req = 1'b1;
            end
            repeat ($urandom_range(3, 12))
            begin
                noisy = compose_string(base_now, text);
                foreach (text[k])
                begin
                    send_char(text[k], (k == 0) || (noisy && $urandom_range(0, 7) == 0),
                              1'b0, NO_RESULT);
                end
            end
            round++;
        end
        settle();

        if (fail_count == 0 && expected_results.size() == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial
    begin
        int unsigned pause;
        pause = 0;
        result_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready)
            begin
                pause = rx_burst ? 0 : $urandom_range(0, 6);
            end
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                pause = LONG_HOLD;
            end
            if (pause != 0)
            begin
                result_bus.ready <= 1'b0;
                pause--;
            end
            else
            begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        parse_result_t want;
        parse_result_t seen;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            seen = '{result_bus.value, result_bus.overflow, result_bus.digits_found,
                     result_bus.end_offset};
            result_seen++;
            if (expected_results.size() == 0)
            begin
                log_failure($sformatf("result %0d unexpected: value=%h ovf=%b dig=%b end=%0d",
                                      result_seen, seen.value, seen.overflow,
                                      seen.digits_found, seen.end_offset));
            end
            else
            begin
                want = expected_results.pop_front();
                if (seen.value !== want.value || seen.overflow !== want.overflow ||
                    seen.digits_found !== want.digits_found ||
                    seen.end_offset !== want.end_offset)
                begin
                    log_failure($sformatf("result %0d: exp %h/%b/%b/%0d got %h/%b/%b/%0d",
                                          result_seen, want.value, want.overflow,
                                          want.digits_found, want.end_offset, seen.value,
                                          seen.overflow, seen.digits_found,
                                          seen.end_offset));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (char_bus.valid && char_bus.ready) ||
            (result_bus.valid && result_bus.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
